/* hdl/oaid_pkg.sv */
// Package for the ordered array engine: operation and status codes, controller
// states, and the command and status bundles between controller and datapath.
// No dependencies.
package oaid_pkg;

  // Default number of elements the array can hold
  localparam int unsigned OAID_CAPACITY = 128;

  // Packed item widths on the stream ports
  localparam int unsigned OAID_IN_TDATA_W  = 48;
  localparam int unsigned OAID_OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_INSERT = 3'd3,
    OP_UPDATE = 3'd4,
    OP_DELETE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_POS  = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_e;

  // RAM read address source
  typedef enum logic [1:0] {
    RA_POS,
    RA_IDX_M1,
    RA_IDX_P1
  } ra_sel_e;

  // RAM write address source
  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_IDX
  } wa_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_LD_COUNT,
    IDX_LD_POS,
    IDX_STEP
  } idx_op_e;

  typedef struct packed {
    logic    item_ld;
    logic    ram_re;
    ra_sel_e ra_sel;
    logic    ram_we;
    wa_sel_e wa_sel;
    logic    wd_rdata;   // write back read data instead of item value
    idx_op_e idx_op;
    logic    idx_down;   // step direction: 1 decrement, 0 increment
    cnt_op_e cnt_op;
    logic    sts_ld;
    status_e sts;
    logic    out_ld;
  } oaid_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_lt_cnt;
    logic       pos_le_cnt;
    logic       full;
    logic       ins_more;
    logic       del_more;
    logic       out_free;
  } oaid_sts_t;

endpackage

/* hdl/oaid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oaid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/oaid_ctrl.sv */
// Controller state machine for the ordered array engine.
// Depends on oaid_pkg; drives the datapath through oaid_cmd_t.
module oaid_ctrl
  import oaid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  oaid_sts_t sts,
  output oaid_cmd_t cmd
);

  state_e state_r, state_nxt;
  op_e    op;

  assign op = op_e'(sts.op);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if ((op == OP_INSERT && sts.pos_le_cnt && !sts.full) ||
            (op == OP_DELETE && sts.pos_lt_cnt)) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT_RD: begin
        if ((op == OP_INSERT && sts.ins_more) || (op == OP_DELETE && sts.del_more)) begin
          state_nxt = S_SHIFT_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = in_tvalid ? S_EXEC : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    cmd.sts   = STS_OK;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EXEC: begin
        cmd.sts_ld = 1'b1;
        case (op)
          OP_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          OP_APPEND: begin
            if (sts.full) begin
              cmd.sts = STS_FULL;
            end else begin
              cmd.ram_we = 1'b1;
              cmd.wa_sel = WA_COUNT;
              cmd.cnt_op = CNT_INC;
            end
          end
          OP_READ: begin
            if (sts.pos_lt_cnt) begin
              cmd.ram_re = 1'b1;
              cmd.ra_sel = RA_POS;
            end else begin
              cmd.sts = STS_POS;
            end
          end
          OP_INSERT: begin
            if (!sts.pos_le_cnt) begin
              cmd.sts = STS_POS;
            end else if (sts.full) begin
              cmd.sts = STS_FULL;
            end else begin
              cmd.idx_op = IDX_LD_COUNT;
            end
          end
          OP_UPDATE: begin
            if (sts.pos_lt_cnt) begin
              cmd.ram_we = 1'b1;
              cmd.wa_sel = WA_POS;
            end else begin
              cmd.sts = STS_POS;
            end
          end
          OP_DELETE: begin
            if (sts.pos_lt_cnt) begin
              cmd.idx_op = IDX_LD_POS;
            end else begin
              cmd.sts = STS_POS;
            end
          end
          default: begin
            cmd.sts = STS_POS;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (op == OP_INSERT) begin
          if (sts.ins_more) begin
            cmd.ram_re = 1'b1;
            cmd.ra_sel = RA_IDX_M1;
          end else begin
            // gap is open: drop the new value in
            cmd.ram_we = 1'b1;
            cmd.wa_sel = WA_POS;
            cmd.cnt_op = CNT_INC;
          end
        end else begin
          if (sts.del_more) begin
            cmd.ram_re = 1'b1;
            cmd.ra_sel = RA_IDX_P1;
          end else begin
            cmd.cnt_op = CNT_DEC;
          end
        end
      end
      S_SHIFT_WR: begin
        cmd.ram_we    = 1'b1;
        cmd.wa_sel    = WA_IDX;
        cmd.wd_rdata  = 1'b1;
        cmd.idx_op    = IDX_STEP;
        cmd.idx_down  = (op == OP_INSERT);
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          in_tready  = 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    cmd.item_ld = in_tvalid && in_tready;
  end

endmodule

/* hdl/oaid_dp.sv */
// Datapath for the ordered array engine: item registers, element count,
// shift index, element RAM and the output register.
// Depends on oaid_pkg and oaid_ram.
module oaid_dp
  import oaid_pkg::*;
#(
  parameter int unsigned CAPACITY = OAID_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_position,
  input  logic [31:0] in_value,
  input  oaid_cmd_t  cmd,
  output oaid_sts_t  sts,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_status,
  output logic [31:0] out_read_value,
  output logic [7:0] out_element_count
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  logic [2:0]    op_r;
  logic [7:0]    pos_r;
  logic [31:0]   val_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  status_e       status_r;
  logic          out_valid_r;
  status_e       out_status_r;
  logic [31:0]   out_rdval_r;
  logic [7:0]    out_cnt_r;

  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic [CW-1:0]   idx_m1, idx_p1;
  logic [AW-1:0]   raddr, waddr;
  logic [31:0]     wdata, rdata;

  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(count_r);
  assign idx_m1  = idx_r - CW'(1);
  assign idx_p1  = idx_r + CW'(1);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
  end

  // Element count
  always_comb begin
    count_nxt = count_r;
    case (cmd.cnt_op)
      CNT_CLR: count_nxt = '0;
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Shift index
  always_comb begin
    idx_nxt = idx_r;
    case (cmd.idx_op)
      IDX_LD_COUNT: idx_nxt = count_r;
      IDX_LD_POS:   idx_nxt = CW'(pos_r);
      IDX_STEP:     idx_nxt = cmd.idx_down ? idx_m1 : idx_p1;
      default:      idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // Status code of the item in flight
  always_ff @(posedge clk) begin
    if (cmd.sts_ld) begin
      status_r <= cmd.sts;
    end
  end

  // RAM address and data selection
  always_comb begin
    case (cmd.ra_sel)
      RA_IDX_M1: raddr = idx_m1[AW-1:0];
      RA_IDX_P1: raddr = idx_p1[AW-1:0];
      default:   raddr = AW'(pos_r);
    endcase
    case (cmd.wa_sel)
      WA_COUNT: waddr = count_r[AW-1:0];
      WA_IDX:   waddr = idx_r[AW-1:0];
      default:  waddr = AW'(pos_r);
    endcase
    wdata = cmd.wd_rdata ? rdata : val_r;
  end

  oaid_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= status_r;
      out_rdval_r  <= (op_e'(op_r) == OP_READ && status_r == STS_OK) ? rdata : '0;
      out_cnt_r    <= 8'(count_r);
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_rdval_r;
  assign out_element_count = out_cnt_r;

  // Flags for the controller
  assign sts.op         = op_r;
  assign sts.pos_lt_cnt = pos_ext < cnt_ext;
  assign sts.pos_le_cnt = pos_ext <= cnt_ext;
  assign sts.full       = count_r == CW'(CAPACITY);
  assign sts.ins_more   = CMPW'(idx_r) > pos_ext;
  assign sts.del_more   = idx_p1 < count_r;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

/* hdl/ordered_array_insert_delete_top.sv */
// Ordered array engine: keeps up to CAPACITY signed 32-bit elements in order
// and applies clear, append, read, insert, update and delete items to them.
// Send one item on the in_ stream; each item gives exactly one result item on
// the out_ stream with a status code, the read value and the element count.
// Clear, append, read, update and rejected items need no shift. An accepted
// insert moves each element from position up one place, and an accepted
// delete moves each element after position down one place. The elements
// live in one single-port-write RAM with a registered read, and a shift
// moves one element at a time (read, then write back one place along).
// A new item is taken in the cycle the previous result is loaded into the
// output register.
// The result waits in the output register while out_tready is low; the engine
// holds in its response state with its next result and takes no more items.
// Reset (rst_n low, synchronous) empties the array and drops any pending
// result; element storage is not cleared.
// Depends on oaid_pkg, oaid_ctrl, oaid_dp and oaid_ram.
module ordered_array_insert_delete_top
  import oaid_pkg::*;
#(
  parameter int unsigned CAPACITY = OAID_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] operation, [10:3] position, [42:11] value, [47:43] zero
  input  logic [OAID_IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] status, [33:2] read_value, [41:34] element_count, [47:42] zero
  output logic [OAID_OUT_TDATA_W-1:0] out_tdata
);

  oaid_cmd_t   cmd;
  oaid_sts_t   sts;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [7:0]  out_element_count;

  oaid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  oaid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_tdata[2:0]),
    .in_position       (in_tdata[10:3]),
    .in_value          (in_tdata[42:11]),
    .cmd               (cmd),
    .sts               (sts),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count)
  );

  // Pack the result item
  assign out_tdata = {6'd0, out_element_count, out_read_value, out_status};

endmodule

/* tb/ordered_array_insert_delete_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for ordered_array_insert_delete_top: queues operation items,
// predicts every result from its own copy of the array and compares the out_ stream.
// Depends on oaid_pkg and the ordered_array_insert_delete_top RTL.
module ordered_array_insert_delete_top_tb;
  import oaid_pkg::*;

  localparam int unsigned CAP          = OAID_CAPACITY;
  localparam logic [2:0]  OP_SPARE6    = 3'd6;
  localparam logic [2:0]  OP_SPARE7    = 3'd7;
  localparam int unsigned LONG_STALL   = 400;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS  = 667;

  typedef struct packed {
    status_e     status;
    logic [31:0] read_value;
    logic [7:0]  element_count;
  } result_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  // [2:0] operation, [10:3] position, [42:11] value, [47:43] zero
  logic [OAID_IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  // [1:0] status, [33:2] read_value, [41:34] element_count, [47:42] zero
  logic [OAID_OUT_TDATA_W-1:0] out_tdata;

  // Items waiting to be offered and results waiting to arrive
  logic [OAID_IN_TDATA_W-1:0] pending_items[$];
  result_t                    expected_results[$];

  // Shadow array and count, advanced as items are accepted
  logic [31:0] shadow_elems[CAP] = '{default: '0};
  int unsigned shadow_count = 0;

  // Count as the queued stream will leave it, used to steer positions
  int unsigned plan_count = 0;

  int unsigned items_queued    = 0;
  int unsigned results_checked = 0;
  int unsigned errors          = 0;
  int unsigned n_ok = 0, n_pos = 0, n_full = 0, max_seen = 0;
  int unsigned tx_idle_pct = 0, rx_idle_pct = 0;
  int unsigned stall_left = 0;
  logic        stall_req = 1'b0;

  ordered_array_insert_delete_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one operation to the shadow array and return the result it gives
  function automatic result_t apply_operation(logic [2:0] op, logic [7:0] pos,
                                              logic [31:0] val);
    result_t     r;
    int unsigned i;
    r.status     = STS_OK;
    r.read_value = '0;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_APPEND: begin
        if (shadow_count >= CAP) begin
          r.status = STS_FULL;
        end else begin
          shadow_elems[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_READ: begin
        if (pos >= shadow_count) r.status = STS_POS;
        else r.read_value = shadow_elems[pos];
      end
      OP_INSERT: begin
        if (pos > shadow_count) begin
          r.status = STS_POS;
        end else if (shadow_count >= CAP) begin
          r.status = STS_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_elems[i] = shadow_elems[i - 1];
          shadow_elems[pos] = val;
          shadow_count++;
        end
      end
      OP_UPDATE: begin
        if (pos >= shadow_count) r.status = STS_POS;
        else shadow_elems[pos] = val;
      end
      OP_DELETE: begin
        if (pos >= shadow_count) begin
          r.status = STS_POS;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i + 1];
          shadow_count--;
        end
      end
      default: r.status = STS_POS;
    endcase
    r.element_count = 8'(shadow_count);
    return r;
  endfunction

  // Pack one item, queue it and track the count it will leave
  task automatic queue_item(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
    pending_items.push_back({5'b0, val, pos, op});
    items_queued++;
    case (op)
      OP_CLEAR:  plan_count = 0;
      OP_APPEND: if (plan_count < CAP) plan_count++;
      OP_INSERT: if (pos <= plan_count && plan_count < CAP) plan_count++;
      OP_DELETE: if (pos < plan_count) plan_count--;
      default: ;
    endcase
  endtask

  // Random element value, weighted towards the extremes
  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // One random operation, mostly at a valid position
  task automatic queue_random_op();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  pos;
    bit          bad;
    pick = $urandom_range(99);
    bad  = ($urandom_range(9) == 0);
    if (pick < 2)       op = OP_CLEAR;
    else if (pick < 4)  op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    else if (pick < 20) op = OP_APPEND;
    else if (pick < 40) op = OP_INSERT;
    else if (pick < 62) op = OP_READ;
    else if (pick < 80) op = OP_UPDATE;
    else                op = OP_DELETE;
    if (op == OP_INSERT) begin
      if (bad) pos = 8'($urandom_range(255, plan_count + 1));
      else pos = 8'($urandom_range(plan_count, 0));
    end else if (bad || plan_count == 0) begin
      pos = 8'($urandom_range(255, plan_count));
    end else begin
      pos = 8'($urandom_range(plan_count - 1, 0));
    end
    queue_item(op, pos, rand_value());
  endtask

  // Grow to capacity, then probe every way of growing a full array and read from it
  task automatic queue_fill_burst();
    while (plan_count < CAP) begin
      if ($urandom_range(1)) queue_item(OP_APPEND, 8'($urandom), rand_value());
      else queue_item(OP_INSERT, 8'($urandom_range(plan_count, 0)), rand_value());
    end
    queue_item(OP_APPEND, 8'd0, rand_value());
    queue_item(OP_INSERT, 8'($urandom_range(CAP, 0)), rand_value());
    queue_item(OP_INSERT, 8'(CAP + 1), rand_value());
    queue_item(OP_READ, 8'(CAP - 1), '0);
    queue_item(OP_READ, 8'(CAP), '0);
    repeat (4) queue_item(OP_READ, 8'($urandom_range(CAP - 1, 0)), '0);
  endtask

  // Shrink towards empty with deletes and reads
  task automatic queue_drain_burst();
    while (plan_count > $urandom_range(8)) begin
      if ($urandom_range(3) == 0) begin
        queue_item(OP_READ, 8'($urandom_range(plan_count - 1, 0)), '0);
      end else begin
        queue_item(OP_DELETE, 8'($urandom_range(plan_count - 1, 0)), '0);
      end
    end
  endtask

  task automatic queue_random_burst();
    case ($urandom_range(9))
      0: queue_fill_burst();
      1: queue_drain_burst();
      2: begin
        queue_item(OP_CLEAR, 8'($urandom), $urandom);
        repeat ($urandom_range(6, 1)) queue_item(OP_APPEND, 8'($urandom), rand_value());
      end
      default: repeat (20) queue_random_op();
    endcase
  endtask

  task automatic queue_directed();
    // Empty array: every indexed access is out of range
    queue_item(OP_READ,   8'd0, '0);
    queue_item(OP_DELETE, 8'd0, '0);
    queue_item(OP_UPDATE, 8'd0, 32'h1234_5678);
    queue_item(OP_INSERT, 8'd1, 32'h1111_1111);
    // Build a small array, insert at the end behaves as append
    queue_item(OP_INSERT, 8'd0, 32'h7fff_ffff);
    queue_item(OP_APPEND, 8'd0, 32'h8000_0000);
    queue_item(OP_APPEND, 8'd0, 32'hffff_ffff);
    queue_item(OP_INSERT, 8'd3, 32'h0000_0000);
    queue_item(OP_INSERT, 8'd1, 32'h1234_5678);
    for (int i = 0; i < 5; i++) queue_item(OP_READ, 8'(i), '0);
    queue_item(OP_UPDATE, 8'd2, 32'ha5a5_a5a5);
    queue_item(OP_READ,   8'd2, '0);
    // Delete the first and then the last element
    queue_item(OP_DELETE, 8'd0, '0);
    queue_item(OP_DELETE, 8'd3, '0);
    queue_item(OP_READ,   8'd255, '0);
    queue_item(OP_SPARE6, 8'd0, 32'hffff_ffff);
    queue_item(OP_SPARE7, 8'd255, 32'h8000_0000);
    queue_item(OP_READ,   8'd1, '0);
    // Clear hides the old contents
    queue_item(OP_CLEAR,  8'd255, 32'hffff_ffff);
    queue_item(OP_READ,   8'd0, '0);
    queue_item(OP_APPEND, 8'd0, 32'h0000_0000);
  endtask

  // Hold off the receiver for a long stretch on request
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_req) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Offer queued items; predict each one as it is accepted
  always @(posedge clk) begin : drive_items
    logic take;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      take = in_tvalid && in_tready;
      if (take) begin
        expected_results.push_back(
          apply_operation(in_tdata[2:0], in_tdata[10:3], in_tdata[42:11]));
      end
      if (!in_tvalid || take) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tdata  <= pending_items.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status        = status_e'(out_tdata[1:0]);
        got.read_value    = out_tdata[33:2];
        got.element_count = out_tdata[41:34];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual %h", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
          if (got.read_value != want.read_value) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, got.read_value);
          end
          if (got.element_count != want.element_count) begin
            errors++;
            $display("%0t: element_count expected %0d actual %0d", $time,
                     want.element_count, got.element_count);
          end
        end
        results_checked++;
        case (got.status)
          STS_OK:   n_ok++;
          STS_POS:  n_pos++;
          STS_FULL: n_full++;
          default: ;
        endcase
        if (got.element_count > max_seen) max_seen = got.element_count;
      end
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus: directed items, then three random phases with different idling
  initial begin : stimulus
    int unsigned phase_start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 12; rx_idle_pct = 61; end
        1: begin tx_idle_pct = 61; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      phase_start = items_queued;
      if (phase == 0) queue_directed();
      queue_fill_burst();
      while (items_queued - phase_start < PHASE_ITEMS) queue_random_burst();
      // Stall the receiver while the sender keeps offering
      if (phase == 2) begin
        stall_req = 1'b1;
        @(negedge clk);
        stall_req = 1'b0;
      end
      // Hold the sender until every result of the phase is in
      while (results_checked < items_queued) @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    $display("Checked %0d results of %0d items: %0d ok, %0d bad position, %0d full",
             results_checked, items_queued, n_ok, n_pos, n_full);
    $display("Largest element count seen %0d, under three idling mixes and a long stall",
             max_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
